// File: sv/cur_pkg.sv
package cur_pkg;

	localparam int CHUNK_BYTES = 512;
	localparam int CB_W = $clog2(CHUNK_BYTES + 1);
	localparam int NSLOT = 12;

	// transmitted byte codes
	localparam logic [7:0] B_READY = 8'h03;
	localparam logic [7:0] B_ACK = 8'h06;
	localparam logic [7:0] B_NAK = 8'h15;
	localparam logic [7:0] B_R = 8'h52;
	localparam logic [7:0] B_E = 8'h45;
	localparam logic [7:0] B_S = 8'h53;
	localparam logic [7:0] B_O = 8'h4F;
	localparam logic [7:0] B_K = 8'h4B;
	localparam logic [7:0] B_G = 8'h47;

	// event codes
	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_BAD_SIZE = 3'd1;
	localparam logic [2:0] EV_DONE = 3'd2;
	localparam logic [2:0] EV_ABORT = 3'd3;
	localparam logic [2:0] EV_LOST = 3'd4;

	// register indexes
	localparam logic [2:0] CFG_READY_TO = 3'd0;
	localparam logic [2:0] CFG_BYTE_TO = 3'd1;
	localparam logic [2:0] CFG_MAX_SIZE = 3'd2;
	localparam logic [2:0] CFG_MAX_RETRY = 3'd3;
	localparam logic [2:0] CFG_LOAD_BASE = 3'd4;

	// command slot positions, emitted lowest first
	localparam int SL_EV_FIRST = 0;
	localparam int SL_PRE = 1;
	localparam int SL_WORD = 4;
	localparam int SL_G = 8;
	localparam int SL_O = 9;
	localparam int SL_EV_END = 10;
	localparam int SL_WRITE = 11;

	typedef enum logic [5:0] {
		PH_ANNOUNCE = 6'b000001,
		PH_WAIT     = 6'b000010,
		PH_HEADER   = 6'b000100,
		PH_RES_K    = 6'b001000,
		PH_DATA     = 6'b010000,
		PH_CRC      = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [21:0] ready_timeout;
		logic [15:0] byte_timeout;
		logic [26:0] max_size;
		logic [3:0]  retry_limit;
		logic [31:0] load_base;
	} cfg_t;

	typedef struct packed {
		logic [NSLOT-1:0] mask;
		logic [2:0]       ev_first;
		logic [7:0]       pb0;
		logic [7:0]       pb1;
		logic [7:0]       pb2;
		logic [31:0]      word;
		logic [2:0]       ev_end;
		logic [31:0]      waddr;
		logic [7:0]       wdata;
	} cmd_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        write_valid;
		logic [31:0] write_addr;
		logic [7:0]  write_data;
		logic [2:0]  event_res;
		logic        last;
	} res_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: sv/cur_front.sv
module cur_front (
	input  logic            clk,
	input  logic            arst_n,
	input  cur_pkg::cfg_t   cfg,
	input  logic            acc,
	input  logic            mode,
	input  logic [7:0]      rx_byte,
	output cur_pkg::cmd_t   cmd,
	output logic            cmd_push
);

	cur_pkg::phase_t ph_q, ph_d;
	logic [21:0] timer_q, timer_d, timer_inc;
	logic [1:0]  hc_q, hc_d;
	logic [23:0] gat_q, gat_d;
	logic [26:0] size_q, size_d, off_q, off_d;
	logic [31:0] chunk_q, chunk_d, good_q, good_d;
	logic        have_q, have_d, res_q, res_d;
	logic [cur_pkg::CB_W-1:0] cbc_q, cbc_d, len;
	logic [3:0]  att_q, att_d, att_n;
	logic [31:0] crc_q, crc_d, full;
	logic [26:0] rem, off_new, start_off;
	logic [31:0] start_chunk;
	logic [43:0] roff;
	logic        do_ann, do_clear, do_start, do_begin, do_go;

	always_comb begin
		rem = size_q - off_q;
		len = (rem > 27'(cur_pkg::CHUNK_BYTES)) ? cur_pkg::CB_W'(cur_pkg::CHUNK_BYTES)
			: rem[cur_pkg::CB_W-1:0];
		timer_inc = (timer_q != '1) ? timer_q + 22'd1 : timer_q;
		full = {rx_byte, gat_q};
		roff = 44'({1'b0, good_q} + 33'd1) * 44'(cur_pkg::CHUNK_BYTES);
		off_new = off_q + 27'(len);
		att_n = (att_q < 4'd15) ? att_q + 4'd1 : att_q;
	end

	always_comb begin
		ph_d = ph_q; timer_d = timer_q; hc_d = hc_q; gat_d = gat_q;
		size_d = size_q; off_d = off_q; chunk_d = chunk_q; good_d = good_q;
		have_d = have_q; res_d = res_q; cbc_d = cbc_q; att_d = att_q; crc_d = crc_q;
		do_ann = 1'b0; do_clear = 1'b0; do_start = 1'b0; do_begin = 1'b0; do_go = 1'b0;
		start_off = '0; start_chunk = '0;
		cmd = '0;
		if (acc) begin
			case (ph_q)
				cur_pkg::PH_WAIT: begin
					if (mode) begin
						timer_d = timer_inc;
						if (timer_inc >= cfg.ready_timeout) do_ann = 1'b1;
					end else if (res_q) begin
						if (rx_byte == cur_pkg::B_O) begin
							ph_d = cur_pkg::PH_RES_K;
							timer_d = '0;
						end else begin
							do_ann = 1'b1;
						end
					end else begin
						gat_d = {16'd0, rx_byte};
						hc_d = 2'd1;
						ph_d = cur_pkg::PH_HEADER;
					end
				end
				cur_pkg::PH_HEADER: begin
					if (!mode) begin
						if (hc_q == 2'd3) begin
							hc_d = '0;
							if (full == '0 || full > {5'd0, cfg.max_size}) begin
								size_d = '0;
								cmd.ev_first = cur_pkg::EV_BAD_SIZE;
								cmd.mask[cur_pkg::SL_EV_FIRST] = 1'b1;
								do_ann = 1'b1;
							end else begin
								size_d = full[26:0];
								cmd.pb0 = cur_pkg::B_O;
								cmd.pb1 = cur_pkg::B_K;
								cmd.mask[cur_pkg::SL_PRE] = 1'b1;
								cmd.mask[cur_pkg::SL_PRE+1] = 1'b1;
								good_d = '0;
								have_d = 1'b0;
								do_start = 1'b1;
							end
						end else begin
							case (hc_q)
								2'd1: gat_d[15:8] = rx_byte;
								2'd2: gat_d[23:16] = rx_byte;
								default: gat_d[7:0] = rx_byte;
							endcase
							hc_d = hc_q + 2'd1;
						end
					end
				end
				cur_pkg::PH_RES_K: begin
					if (mode) begin
						timer_d = timer_inc;
						if (timer_inc >= {6'd0, cfg.byte_timeout}) do_ann = 1'b1;
					end else if (rx_byte == cur_pkg::B_K) begin
						if (have_q) begin
							start_off = (roff > {17'd0, size_q}) ? size_q : roff[26:0];
							start_chunk = good_q + 32'd1;
						end
						do_start = 1'b1;
					end else begin
						do_ann = 1'b1;
					end
				end
				cur_pkg::PH_DATA: begin
					if (mode) begin
						timer_d = timer_inc;
						if (timer_inc >= {6'd0, cfg.byte_timeout}) begin
							cmd.ev_first = cur_pkg::EV_LOST;
							cmd.mask[cur_pkg::SL_EV_FIRST] = 1'b1;
							res_d = 1'b1;
							do_ann = 1'b1;
						end
					end else begin
						cmd.mask[cur_pkg::SL_WRITE] = 1'b1;
						cmd.waddr = cfg.load_base + 32'(off_q) + 32'(cbc_q);
						cmd.wdata = rx_byte;
						crc_d = cur_pkg::crc_byte(crc_q, rx_byte);
						cbc_d = cbc_q + 1'b1;
						timer_d = '0;
						if ({1'b0, cbc_q} + 1'b1 >= {1'b0, len}) begin
							hc_d = '0;
							gat_d = '0;
							ph_d = cur_pkg::PH_CRC;
						end
					end
				end
				cur_pkg::PH_CRC: begin
					if (mode) begin
						timer_d = timer_inc;
						if (timer_inc >= {6'd0, cfg.byte_timeout}) begin
							cmd.ev_first = cur_pkg::EV_LOST;
							cmd.mask[cur_pkg::SL_EV_FIRST] = 1'b1;
							res_d = 1'b1;
							do_ann = 1'b1;
						end
					end else begin
						timer_d = '0;
						if (hc_q == 2'd3) begin
							hc_d = '0;
							cmd.word = chunk_q;
							cmd.mask[cur_pkg::SL_PRE] = 1'b1;
							cmd.mask[cur_pkg::SL_WORD +: 4] = 4'hF;
							if (~crc_q == full) begin
								cmd.pb0 = cur_pkg::B_ACK;
								good_d = chunk_q;
								have_d = 1'b1;
								off_d = off_new;
								chunk_d = chunk_q + 32'd1;
								att_d = '0;
								if (off_new >= size_q) do_go = 1'b1;
								else do_begin = 1'b1;
							end else begin
								cmd.pb0 = cur_pkg::B_NAK;
								att_d = att_n;
								if (att_n >= cfg.retry_limit) begin
									cmd.ev_end = cur_pkg::EV_ABORT;
									cmd.mask[cur_pkg::SL_EV_END] = 1'b1;
									do_clear = 1'b1;
								end else begin
									do_begin = 1'b1;
								end
							end
						end else begin
							case (hc_q)
								2'd1: gat_d[15:8] = rx_byte;
								2'd2: gat_d[23:16] = rx_byte;
								default: gat_d[7:0] = rx_byte;
							endcase
							hc_d = hc_q + 2'd1;
						end
					end
				end
				default: do_ann = 1'b1;
			endcase

			if (do_start) begin
				res_d = 1'b0;
				att_d = '0;
				off_d = start_off;
				chunk_d = start_chunk;
				if (start_off >= size_d) do_go = 1'b1;
				else do_begin = 1'b1;
			end
			if (do_begin) begin
				cbc_d = '0; hc_d = '0; crc_d = '1; gat_d = '0; timer_d = '0;
				ph_d = cur_pkg::PH_DATA;
			end
			if (do_go) begin
				cmd.mask[cur_pkg::SL_G] = 1'b1;
				cmd.mask[cur_pkg::SL_O] = 1'b1;
				cmd.mask[cur_pkg::SL_EV_END] = 1'b1;
				cmd.ev_end = cur_pkg::EV_DONE;
				do_clear = 1'b1;
			end
			if (do_clear) begin
				res_d = 1'b0; good_d = '0; have_d = 1'b0; size_d = '0; off_d = '0;
				chunk_d = '0; att_d = '0; cbc_d = '0; hc_d = '0; crc_d = '1;
				gat_d = '0; timer_d = '0;
				ph_d = cur_pkg::PH_ANNOUNCE;
			end
			if (do_ann) begin
				cmd.mask[cur_pkg::SL_PRE +: 3] = 3'b111;
				if (res_d) begin
					cmd.pb0 = cur_pkg::B_R;
					cmd.pb1 = cur_pkg::B_E;
					cmd.pb2 = cur_pkg::B_S;
					cmd.word = good_d;
					cmd.mask[cur_pkg::SL_WORD +: 4] = 4'hF;
				end else begin
					cmd.pb0 = cur_pkg::B_READY;
					cmd.pb1 = cur_pkg::B_READY;
					cmd.pb2 = cur_pkg::B_READY;
				end
				ph_d = cur_pkg::PH_WAIT;
				timer_d = '0;
			end
		end
	end

	assign cmd_push = acc && (cmd.mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= cur_pkg::PH_ANNOUNCE;
			timer_q <= '0; hc_q <= '0; gat_q <= '0; size_q <= '0; off_q <= '0;
			chunk_q <= '0; good_q <= '0; have_q <= 1'b0; res_q <= 1'b0;
			cbc_q <= '0; att_q <= '0; crc_q <= '1;
		end else begin
			ph_q <= ph_d;
			timer_q <= timer_d; hc_q <= hc_d; gat_q <= gat_d; size_q <= size_d;
			off_q <= off_d; chunk_q <= chunk_d; good_q <= good_d; have_q <= have_d;
			res_q <= res_d; cbc_q <= cbc_d; att_q <= att_d; crc_q <= crc_d;
		end
	end

endmodule

// File: sv/cur_queue.sv
module cur_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cur_pkg::cmd_t push_cmd,
	input  logic          pop,
	output cur_pkg::cmd_t head,
	output logic          head_valid,
	output logic          full
);

	cur_pkg::cmd_t ent_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign head = ent_q[rp_q];
	assign head_valid = (cnt_q != 2'd0);
	assign full = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: sv/cur_back.sv
module cur_back (
	input  logic          clk,
	input  logic          arst_n,
	input  cur_pkg::cmd_t head,
	input  logic          head_valid,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output cur_pkg::res_t res
);

	logic [cur_pkg::NSLOT-1:0] done_q, pend, sel, rem;
	logic emit, ov_q;
	cur_pkg::res_t res_q, nxt;

	always_comb begin
		pend = head.mask & ~done_q;
		sel = '0;
		for (int i = cur_pkg::NSLOT - 1; i >= 0; i--) begin
			if (pend[i]) sel = cur_pkg::NSLOT'(1) << i;
		end
		rem = pend & ~sel;
		nxt = '0;
		nxt.last = (rem == '0);
		case (1'b1)
			sel[cur_pkg::SL_EV_FIRST]: nxt.event_res = head.ev_first;
			sel[cur_pkg::SL_PRE]: begin nxt.tx_valid = 1'b1; nxt.tx_byte = head.pb0; end
			sel[cur_pkg::SL_PRE+1]: begin nxt.tx_valid = 1'b1; nxt.tx_byte = head.pb1; end
			sel[cur_pkg::SL_PRE+2]: begin nxt.tx_valid = 1'b1; nxt.tx_byte = head.pb2; end
			sel[cur_pkg::SL_WORD]: begin nxt.tx_valid = 1'b1; nxt.tx_byte = head.word[7:0]; end
			sel[cur_pkg::SL_WORD+1]: begin
				nxt.tx_valid = 1'b1; nxt.tx_byte = head.word[15:8];
			end
			sel[cur_pkg::SL_WORD+2]: begin
				nxt.tx_valid = 1'b1; nxt.tx_byte = head.word[23:16];
			end
			sel[cur_pkg::SL_WORD+3]: begin
				nxt.tx_valid = 1'b1; nxt.tx_byte = head.word[31:24];
			end
			sel[cur_pkg::SL_G]: begin nxt.tx_valid = 1'b1; nxt.tx_byte = cur_pkg::B_G; end
			sel[cur_pkg::SL_O]: begin nxt.tx_valid = 1'b1; nxt.tx_byte = cur_pkg::B_O; end
			sel[cur_pkg::SL_EV_END]: nxt.event_res = head.ev_end;
			sel[cur_pkg::SL_WRITE]: begin
				nxt.write_valid = 1'b1;
				nxt.write_addr = head.waddr;
				nxt.write_data = head.wdata;
			end
			default: nxt = '0;
		endcase
	end

	assign emit = head_valid && (!ov_q || out_ready);
	assign pop = emit && (rem == '0);
	assign out_valid = ov_q;
	assign res = res_q;

	always_ff @(posedge clk) begin
		if (emit) res_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			done_q <= '0;
		end else begin
			if (emit) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			if (pop) done_q <= '0;
			else if (emit) done_q <= done_q | sel;
		end
	end

endmodule

// File: sv/chunked_upload_receiver_unit.sv
// Receiver for a chunked serial image upload.
// Input channel (in_valid/in_ready): one transaction per received byte (mode 0)
// or per timer tick (mode 1). The front end takes a transaction every cycle
// while its two-entry command queue has room, so in_ready drops only when
// the queue is full.
// Output channel (out_valid/out_ready): one transaction per result, up to
// eight per input; last marks the final result of that input. Inputs that
// cause no result give no output transaction.
// The accepting edge writes the queue; the output register loads from the
// queue head while the back end is free (out_valid low or out_ready high),
// and the back end streams one result a cycle while out_ready is high.
// A stalled receiver holds the output register; the queue then fills and
// in_ready falls until it drains.
// Reset (arst_n low): announce pending, queue empty, registers at defaults.
// The user must write config (cfg_we/cfg_index/cfg_data) only while idle;
// the block itself does not enforce this.
module chunked_upload_receiver_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        write_valid,
	output logic [31:0] write_addr,
	output logic [7:0]  write_data,
	output logic [2:0]  event_res,
	output logic        last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cur_pkg::cfg_t cfg_q;
	cur_pkg::cmd_t cmd, head;
	cur_pkg::res_t res;
	logic acc, push, pop, head_valid, full;

	// config registers, out-of-range index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ready_timeout <= 22'd3000000;
			cfg_q.byte_timeout <= 16'd1000;
			cfg_q.max_size <= 27'h7F80000;
			cfg_q.retry_limit <= 4'd3;
			cfg_q.load_base <= 32'h00080000;
		end else if (cfg_we) begin
			case (cfg_index)
				cur_pkg::CFG_READY_TO: cfg_q.ready_timeout <= cfg_data[21:0];
				cur_pkg::CFG_BYTE_TO: cfg_q.byte_timeout <= cfg_data[15:0];
				cur_pkg::CFG_MAX_SIZE: cfg_q.max_size <= cfg_data[26:0];
				cur_pkg::CFG_MAX_RETRY: cfg_q.retry_limit <= cfg_data[3:0];
				cur_pkg::CFG_LOAD_BASE: cfg_q.load_base <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !full;
	assign acc = in_valid && in_ready;

	// front end: protocol state machine, one transaction per cycle while the queue has room
	cur_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .acc(acc), .mode(mode),
		.rx_byte(rx_byte), .cmd(cmd), .cmd_push(push)
	);

	// decoupling queue of result commands
	cur_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_cmd(cmd), .pop(pop),
		.head(head), .head_valid(head_valid), .full(full)
	);

	// back end: expands a command into its result transactions
	cur_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .head_valid(head_valid), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready), .res(res)
	);

	assign tx_valid = res.tx_valid;
	assign tx_byte = res.tx_byte;
	assign write_valid = res.write_valid;
	assign write_addr = res.write_addr;
	assign write_data = res.write_data;
	assign event_res = res.event_res;
	assign last = res.last;

	// a result carries one kind of payload only
	a_write_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_valid |-> !tx_valid && event_res == cur_pkg::EV_NONE)
		else $error("write result carries another payload");

	a_event_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != cur_pkg::EV_NONE |-> !tx_valid && !write_valid)
		else $error("event result carries another payload");

	// a data write is always the only result of its byte
	a_write_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_valid |-> last)
		else $error("write result not marked last");

endmodule
